FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the frame receive checker RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, masked while reset is high.
`define FCR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define FCR_NEVER(lbl, clk, rst, cond, msg) \
  `FCR_ASSERT(lbl, clk, rst, !(cond), msg)

`endif

FILE: hdl/fcr_pkg.sv
// ---------------------------------------------------------------------------
// fcr_pkg
// Types and constants of the frame receive checker.
// ---------------------------------------------------------------------------
package fcr_pkg;

  typedef enum logic [1:0] {
    V_ACCEPT = 2'd0,
    V_DUP    = 2'd1,
    V_NACK   = 2'd2,
    V_DONE   = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_READ,
    ST_DATA
  } state_t;

  localparam logic CFG_ACK  = 1'b0;
  localparam logic CFG_NACK = 1'b1;

  localparam logic [3:0] SEQ_RESET   = 4'd15;
  localparam logic [3:0] ACK_RESET   = 4'd0;
  localparam logic [3:0] NACK_RESET  = 4'd1;
  localparam logic [3:0] DONE_WINDOW = 4'd4;

  typedef struct packed {
    logic [3:0] frame_seq;
    logic [3:0] frame_kind;
    logic [5:0] payload_len;
    logic [7:0] payload_byte;
    logic [7:0] parity_byte;
    logic       frame_end;
  } rx_item_t;

  typedef struct packed {
    verdict_t   verdict;
    logic [3:0] kind_out;
    logic [3:0] seq_out;
    logic [7:0] result_value;
    logic [7:0] data_out;
    logic       run_last;
  } tx_item_t;

endpackage

FILE: hdl/frame_receive_checker_core.sv
// ---------------------------------------------------------------------------
// frame_receive_checker_core
// Stores frame payload, checks parity and sequence, replays accepted frames.
// ---------------------------------------------------------------------------
// Output: a rejected frame's result is loaded at the edge that takes its
//   final byte; an accepted frame's bytes are read in ST_READ, loaded in ST_DATA.
// Throughput: one byte per cycle on receive while no result waits; an accepted
//   frame replays its N stored bytes, each by a store read, then a load.
// Reset: synchronous; last sequence 15, ack code 0, nack code 1; the payload
//   store is not cleared.
`include "assert_macros.svh"

module frame_receive_checker_core #(
  parameter int PAYLOAD_BYTES = 63
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rx_valid,
  output logic              rx_stall,
  input  fcr_pkg::rx_item_t rx_data,
  output logic              tx_valid,
  input  logic              tx_stall,
  output fcr_pkg::tx_item_t tx_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [3:0]        cfg_data
);

  localparam int CNT_W  = $clog2(PAYLOAD_BYTES + 1);
  localparam int ADDR_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(PAYLOAD_BYTES);

  fcr_pkg::state_t   state, state_next;
  fcr_pkg::verdict_t verdict;

  logic [3:0]       ack_code;
  logic [3:0]       nack_code;
  logic [3:0]       accepted_seq;
  logic [7:0]       parity_acc;
  logic [7:0]       acc_next;
  logic [CNT_W-1:0] byte_index;
  logic [CNT_W-1:0] count_next;
  logic [7:0]       first_byte;
  logic [7:0]       byte0_now;
  logic [CNT_W-1:0] s_count;
  logic [CNT_W-1:0] rd_idx;
  logic [3:0]       s_kind;
  logic [7:0]       s_value;
  logic [7:0]       rd_data;

  logic rx_take;
  logic store_ok;
  logic frame_done;
  logic out_free;
  logic rd_en;
  logic data_load;
  logic reject_load;
  logic run_end;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_code  <= fcr_pkg::ACK_RESET;
      nack_code <= fcr_pkg::NACK_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        fcr_pkg::CFG_ACK:  ack_code  <= cfg_data;
        fcr_pkg::CFG_NACK: nack_code <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rx_take    = rx_valid && !rx_stall;
  assign out_free   = !tx_valid || !tx_stall;
  assign store_ok   = byte_index < CNT_MAX;
  assign frame_done = rx_take && rx_data.frame_end;
  assign run_end    = (rd_idx + CNT_W'(1)) == s_count;

  always_comb begin
    acc_next = parity_acc;
    if (store_ok && 8'(byte_index) < 8'(rx_data.payload_len)) begin
      acc_next = parity_acc ^ rx_data.payload_byte;
    end
  end

  assign count_next = store_ok ? byte_index + CNT_W'(1) : byte_index;
  assign byte0_now  = (byte_index == '0) ? rx_data.payload_byte : first_byte;

  fcr_verdict u_verdict (
    .seq          (rx_data.frame_seq),
    .accepted_seq (accepted_seq),
    .acc          (acc_next),
    .parity       (rx_data.parity_byte),
    .verdict      (verdict)
  );

  fcr_store #(
    .DEPTH  (PAYLOAD_BYTES),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (rx_take && store_ok),
    .wr_addr (byte_index[ADDR_W-1:0]),
    .wr_data (rx_data.payload_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      fcr_pkg::ST_RECV: begin
        if (frame_done && verdict == fcr_pkg::V_ACCEPT) begin
          state_next = fcr_pkg::ST_READ;
        end
      end
      fcr_pkg::ST_READ: state_next = fcr_pkg::ST_DATA;
      fcr_pkg::ST_DATA: begin
        if (out_free) begin
          state_next = run_end ? fcr_pkg::ST_RECV : fcr_pkg::ST_READ;
        end
      end
      default: state_next = fcr_pkg::ST_RECV;
    endcase
  end

  always_comb begin
    rx_stall    = 1'b1;
    rd_en       = 1'b0;
    data_load   = 1'b0;
    reject_load = 1'b0;
    case (state)
      fcr_pkg::ST_RECV: begin
        rx_stall    = !out_free;
        reject_load = frame_done && verdict != fcr_pkg::V_ACCEPT;
      end
      fcr_pkg::ST_READ: rd_en = 1'b1;
      fcr_pkg::ST_DATA: data_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcr_pkg::ST_RECV;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_seq <= fcr_pkg::SEQ_RESET;
      parity_acc   <= '0;
      byte_index   <= '0;
    end else if (rx_take) begin
      if (rx_data.frame_end) begin
        parity_acc <= '0;
        byte_index <= '0;
        if (verdict == fcr_pkg::V_ACCEPT) begin
          accepted_seq <= rx_data.frame_seq;
        end
      end else begin
        parity_acc <= acc_next;
        byte_index <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take && byte_index == '0) begin
      first_byte <= rx_data.payload_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done && verdict == fcr_pkg::V_ACCEPT) begin
      s_count <= count_next;
      s_kind  <= rx_data.frame_kind;
      if (rx_data.frame_kind == ack_code || rx_data.frame_kind == nack_code) begin
        s_value <= byte0_now;
      end else begin
        s_value <= 8'(rx_data.payload_len);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (frame_done) begin
      rd_idx <= '0;
    end else if (data_load) begin
      rd_idx <= rd_idx + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else if (reject_load || data_load) begin
      tx_valid <= 1'b1;
    end else if (!tx_stall) begin
      tx_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (reject_load) begin
      tx_data.verdict      <= verdict;
      tx_data.kind_out     <= (verdict == fcr_pkg::V_NACK) ? nack_code
                                                          : rx_data.frame_kind;
      tx_data.seq_out      <= (verdict == fcr_pkg::V_DUP) ? rx_data.frame_seq : 4'd0;
      tx_data.result_value <= 8'd0;
      tx_data.data_out     <= 8'd0;
      tx_data.run_last     <= 1'b1;
    end else if (data_load) begin
      tx_data.verdict      <= fcr_pkg::V_ACCEPT;
      tx_data.kind_out     <= s_kind;
      tx_data.seq_out      <= 4'd0;
      tx_data.result_value <= s_value;
      tx_data.data_out     <= rd_data;
      tx_data.run_last     <= run_end;
    end
  end

  `FCR_ASSERT(a_rx_only_recv, clk, rst, rx_take |-> state == fcr_pkg::ST_RECV,
              "byte taken outside receive state")
  `FCR_ASSERT(a_rd_in_range, clk, rst,
              state != fcr_pkg::ST_RECV |-> (rd_idx < s_count && s_count <= CNT_MAX),
              "replay index beyond stored count")
  `FCR_ASSERT(a_reject_single, clk, rst,
              tx_valid && tx_data.verdict != fcr_pkg::V_ACCEPT |-> tx_data.run_last,
              "rejected frame result without run_last")
  `FCR_ASSERT(a_run_end_recv, clk, rst, data_load && run_end |=> state == fcr_pkg::ST_RECV,
              "replay did not return to receive after last byte")
  `FCR_NEVER(a_no_overrun, clk, rst, byte_index > CNT_MAX,
             "byte index beyond store depth")

endmodule

FILE: hdl/fcr_store.sv
// ---------------------------------------------------------------------------
// fcr_store
// Payload byte store: one write port, one registered read port.
// ---------------------------------------------------------------------------
module fcr_store #(
  parameter int DEPTH  = 63,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/fcr_verdict.sv
// ---------------------------------------------------------------------------
// fcr_verdict
// Frame-end decision: duplicate, parity, window and sequence checks.
// ---------------------------------------------------------------------------
module fcr_verdict (
  input  logic [3:0]       seq,
  input  logic [3:0]       accepted_seq,
  input  logic [7:0]       acc,
  input  logic [7:0]       parity,
  output fcr_pkg::verdict_t verdict
);

  logic [3:0] expected;
  logic [3:0] lag;

  assign expected = accepted_seq + 4'd1;
  assign lag      = expected - seq;

  always_comb begin
    if (seq == accepted_seq) begin
      verdict = fcr_pkg::V_DUP;
    end else if (acc != parity) begin
      verdict = fcr_pkg::V_NACK;
    end else if (lag != 4'd0 && lag <= fcr_pkg::DONE_WINDOW) begin
      verdict = fcr_pkg::V_DONE;
    end else if (seq != expected) begin
      verdict = fcr_pkg::V_NACK;
    end else begin
      verdict = fcr_pkg::V_ACCEPT;
    end
  end

endmodule
